// ===== design/pfe_pkg.sv =====
// Shared types and constants for the postfix expression evaluator.
// Used by every module of the block; depends on nothing.
package pfe_pkg;

    localparam int DATA_W          = 32;
    localparam int STACK_DEPTH_DEF = 64;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [DATA_W-1:0] VAL_ERROR = 32'h8000_0000;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_ADD  = 8'h2B;
    localparam logic [7:0] CHAR_SUB  = 8'h2D;
    localparam logic [7:0] CHAR_MUL  = 8'h2A;
    localparam logic [7:0] CHAR_DIV  = 8'h2F;

    typedef enum logic [2:0] {
        OP_DIGIT = 3'd0,
        OP_ADD   = 3'd1,
        OP_SUB   = 3'd2,
        OP_MUL   = 3'd3,
        OP_DIV   = 3'd4,
        OP_BAD   = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_DIVZERO   = 3'd2,
        ST_BADCHAR   = 3'd3,
        ST_OVERFLOW  = 3'd4,
        ST_EMPTY     = 3'd5
    } status_t;

    // One classified request as it travels from front to back.
    typedef struct packed {
        op_t        op;
        logic [3:0] digit;
        logic       last;
    } cmd_t;

endpackage

// ===== design/pfe_front.sv =====
// Front end: accepts characters and classifies them into commands.
// Depends on pfe_pkg.
module pfe_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       ch,
    input  logic             last,
    input  logic             q_full,
    output logic             q_push,
    output pfe_pkg::cmd_t    q_data
);

    logic          valid_reg;
    logic          valid_next;
    pfe_pkg::cmd_t cmd_reg;
    pfe_pkg::cmd_t cmd_next;
    logic          accept;

    assign in_stall = valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign q_push   = valid_reg && !q_full;
    assign q_data   = cmd_reg;

    always_comb
    begin
        cmd_next       = cmd_reg;
        cmd_next.digit = ch[3:0];
        cmd_next.last  = last;
        priority if (ch >= pfe_pkg::CHAR_ZERO && ch <= pfe_pkg::CHAR_NINE)
        begin
            cmd_next.op = pfe_pkg::OP_DIGIT;
        end
        else if (ch == pfe_pkg::CHAR_ADD)
        begin
            cmd_next.op = pfe_pkg::OP_ADD;
        end
        else if (ch == pfe_pkg::CHAR_SUB)
        begin
            cmd_next.op = pfe_pkg::OP_SUB;
        end
        else if (ch == pfe_pkg::CHAR_MUL)
        begin
            cmd_next.op = pfe_pkg::OP_MUL;
        end
        else if (ch == pfe_pkg::CHAR_DIV)
        begin
            cmd_next.op = pfe_pkg::OP_DIV;
        end
        else
        begin
            cmd_next.op = pfe_pkg::OP_BAD;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (q_push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // hold the command until the queue takes it
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

// ===== design/pfe_queue.sv =====
// Short command queue between front and back.
// Depends on pfe_pkg.
module pfe_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pfe_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output pfe_pkg::cmd_t head,
    output logic          empty
);

    localparam int QD  = pfe_pkg::QUEUE_DEPTH;
    localparam int QAW = (QD > 1) ? $clog2(QD) : 1;
    localparam int QCW = $clog2(QD + 1);

    pfe_pkg::cmd_t  entry_reg [QD];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW-1:0] rd_ptr_next;
    logic [QCW-1:0] fill_reg;
    logic [QCW-1:0] fill_next;
    logic           do_push;
    logic           do_pop;

    assign full    = (fill_reg == QCW'(QD));
    assign empty   = (fill_reg == '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QD - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QD - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/pfe_div.sv =====
// Iterative signed divider, truncating toward zero, one quotient bit a cycle.
// Depends on pfe_pkg.
module pfe_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pfe_pkg::DATA_W-1:0]  dividend,
    input  logic [pfe_pkg::DATA_W-1:0]  divisor,
    output logic                        done,
    output logic [pfe_pkg::DATA_W-1:0]  quotient
);

    localparam int W  = pfe_pkg::DATA_W;
    localparam int SW = $clog2(W + 1);

    logic [W-1:0]  quo_reg;
    logic [W-1:0]  quo_next;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  rem_next;
    logic [W-1:0]  dvs_reg;
    logic [W-1:0]  dvs_next;
    logic          neg_reg;
    logic          neg_next;
    logic [SW-1:0] steps_reg;
    logic [SW-1:0] steps_next;
    logic          done_reg;
    logic          done_next;
    logic [W:0]    shifted;
    logic [W:0]    diff;
    logic          a_neg;
    logic          b_neg;

    assign a_neg    = dividend[W-1];
    assign b_neg    = divisor[W-1];
    assign shifted  = {rem_reg, quo_reg[W-1]};
    assign diff     = shifted - {1'b0, dvs_reg};
    assign done     = done_reg;
    assign quotient = neg_reg ? (W'(0) - quo_reg) : quo_reg;

    always_comb
    begin
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        neg_next   = neg_reg;
        steps_next = steps_reg;
        done_next  = 1'b0;
        if (start)
        begin
            // work on magnitudes, fix the sign at the end
            quo_next   = a_neg ? (W'(0) - dividend) : dividend;
            dvs_next   = b_neg ? (W'(0) - divisor) : divisor;
            neg_next   = a_neg != b_neg;
            rem_next   = '0;
            steps_next = SW'(W);
        end
        else if (steps_reg != '0)
        begin
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            steps_next = steps_reg - 1'b1;
            done_next  = (steps_reg == SW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            steps_reg <= steps_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

endmodule

// ===== design/pfe_back.sv =====
// Back end: operand stack, arithmetic sequencer and result register.
// Depends on pfe_pkg and pfe_div.
module pfe_back
#(
    parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  pfe_pkg::cmd_t               head,
    input  logic                        q_empty,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [pfe_pkg::DATA_W-1:0] value,
    output logic [2:0]                  status
);

    localparam int W  = pfe_pkg::DATA_W;
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_DIV  = 5'b00100,
        S_WB   = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [CW-1:0]     count_m2;
    pfe_pkg::status_t  err_reg;
    pfe_pkg::status_t  err_next;
    logic [W-1:0]      top_reg;
    logic [W-1:0]      top_next;
    logic [W-1:0]      res_reg;
    logic [W-1:0]      res_next;
    pfe_pkg::cmd_t     cmd_reg;
    pfe_pkg::cmd_t     cmd_next;
    logic [W-1:0]      stack_mem [STACK_DEPTH];
    logic [W-1:0]      rd_data_reg;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [W-1:0]      wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              div_start;
    logic              div_done;
    logic [W-1:0]      div_q;
    logic              out_free;
    logic              out_load;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [W-1:0]      value_reg;
    logic [W-1:0]      value_next;
    pfe_pkg::status_t  status_reg;
    pfe_pkg::status_t  status_next;

    assign count_m2  = count_reg - CW'(2);
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

    pfe_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rd_data_reg),
        .divisor  (top_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        err_next   = err_reg;
        top_next   = top_reg;
        res_next   = res_reg;
        cmd_next   = cmd_reg;
        q_pop      = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = count_m2[AW-1:0];
        wr_data    = res_reg;
        rd_en      = 1'b0;
        rd_addr    = count_m2[AW-1:0];
        div_start  = 1'b0;
        out_load   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = head;
                    state_next = head.last ? S_EMIT : S_IDLE;
                    if (err_reg == pfe_pkg::ST_OK)
                    begin
                        unique case (head.op)
                            pfe_pkg::OP_DIGIT:
                            begin
                                if (count_reg == CW'(STACK_DEPTH))
                                begin
                                    err_next = pfe_pkg::ST_OVERFLOW;
                                end
                                else
                                begin
                                    wr_en      = 1'b1;
                                    wr_addr    = count_reg[AW-1:0];
                                    wr_data    = {{(W-4){1'b0}}, head.digit};
                                    top_next   = {{(W-4){1'b0}}, head.digit};
                                    count_next = count_reg + 1'b1;
                                end
                            end
                            pfe_pkg::OP_ADD, pfe_pkg::OP_SUB,
                            pfe_pkg::OP_MUL, pfe_pkg::OP_DIV:
                            begin
                                if (count_reg < CW'(2))
                                begin
                                    err_next = pfe_pkg::ST_UNDERFLOW;
                                end
                                else
                                begin
                                    // fetch the first operand; the second is top_reg
                                    rd_en      = 1'b1;
                                    state_next = S_READ;
                                end
                            end
                            default:
                            begin
                                err_next = pfe_pkg::ST_BADCHAR;
                            end
                        endcase
                    end
                end
            end
            S_READ:
            begin
                state_next = S_WB;
                unique case (cmd_reg.op)
                    pfe_pkg::OP_ADD: res_next = rd_data_reg + top_reg;
                    pfe_pkg::OP_SUB: res_next = rd_data_reg - top_reg;
                    pfe_pkg::OP_MUL: res_next = rd_data_reg * top_reg;
                    default:
                    begin
                        if (top_reg == '0)
                        begin
                            err_next   = pfe_pkg::ST_DIVZERO;
                            state_next = cmd_reg.last ? S_EMIT : S_IDLE;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                endcase
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_next   = div_q;
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                // drop the second operand, overwrite the first with the result
                wr_en      = 1'b1;
                top_next   = res_reg;
                count_next = count_reg - 1'b1;
                state_next = cmd_reg.last ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    count_next = '0;
                    err_next   = pfe_pkg::ST_OK;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        value_next  = pfe_pkg::VAL_ERROR;
        status_next = err_reg;
        if (err_reg == pfe_pkg::ST_OK)
        begin
            if (count_reg == '0)
            begin
                status_next = pfe_pkg::ST_EMPTY;
            end
            else
            begin
                value_next = top_reg;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            err_reg       <= pfe_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        res_reg <= res_next;
        cmd_reg <= cmd_next;
        if (out_load)
        begin
            value_reg  <= value_next;
            status_reg <= status_next;
        end
    end

    // operand stack storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

endmodule

// ===== design/postfix_expression_evaluator.sv =====
// Postfix expression evaluator, one character per request.
// Back end steps: a digit is handled in S_IDLE, + - * pass S_READ and S_WB, / passes S_READ,
// S_DIV (iterative divider) and S_WB; last adds S_EMIT. New characters queue up meanwhile.
// Reset: rst_n clears all control state asynchronously; stack storage is not cleared.
// Depends on pfe_pkg, pfe_front, pfe_queue, pfe_back.
module postfix_expression_evaluator
#(
    parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         ch,
    input  logic                               last,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [pfe_pkg::DATA_W-1:0]  value,
    output logic [2:0]                         status
);

    // Front end classifies each character into a command and hands it to a
    // short queue. The back end drains the queue at its own pace: digits are
    // pushed from the idle state, + - * read the first operand from stack memory
    // (the top lives in a register), compute, then write back. Division runs
    // through the iterative divider. Once an error is latched the back end
    // only drops commands until the last one, then emits and clears.

    pfe_pkg::cmd_t q_in;
    pfe_pkg::cmd_t q_head;
    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;

    pfe_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .ch       (ch),
        .last     (last),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    pfe_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    pfe_back
    #(
        .STACK_DEPTH (STACK_DEPTH)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .status    (status)
    );

endmodule

// ===== bench/pfe_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the postfix expression evaluator: predicts each expression result
// from the accepted character requests and compares it with what the block returns.
// Depends on pfe_pkg.
module pfe_result_checker
    import pfe_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic [7:0]               ch,
    input  logic                     last,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic signed [DATA_W-1:0] value,
    input  logic [2:0]               status,
    output int                       fail_count,
    output int                       pending,
    output int                       results_checked,
    output int                       error_results
);

    logic [DATA_W-1:0] opnd [STACK_DEPTH_DEF];
    int                opnd_depth;
    status_t           latched_err;
    logic [DATA_W-1:0] pending_values [$];
    status_t           pending_status [$];

    initial
    begin
        opnd_depth      = 0;
        latched_err     = ST_OK;
        fail_count      = 0;
        pending         = 0;
        results_checked = 0;
        error_results   = 0;
    end

    function automatic op_t classify(logic [7:0] c);
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
            return OP_DIGIT;
        case (c)
            CHAR_ADD: return OP_ADD;
            CHAR_SUB: return OP_SUB;
            CHAR_MUL: return OP_MUL;
            CHAR_DIV: return OP_DIV;
            default:  return OP_BAD;
        endcase
    endfunction

    // Signed divide that truncates toward zero and wraps the most negative quotient.
    function automatic logic [DATA_W-1:0] quot_trunc(logic [DATA_W-1:0] num,
                                                     logic [DATA_W-1:0] den);
        logic [DATA_W-1:0] mag_n;
        logic [DATA_W-1:0] mag_d;
        logic [DATA_W-1:0] q;
        mag_n = num[DATA_W-1] ? -num : num;
        mag_d = den[DATA_W-1] ? -den : den;
        q     = mag_n / mag_d;
        return (num[DATA_W-1] ^ den[DATA_W-1]) ? -q : q;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        fail_count++;
    endtask

    // Advance the stack for one character; queue a result on the closing one.
    task automatic eval_char(logic [7:0] c, logic fin);
        op_t               op;
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] rhs;
        logic [DATA_W-1:0] res;
        logic [DATA_W-1:0] top;
        status_t           st;
        op = classify(c);
        if (latched_err == ST_OK)
        begin
            if (op == OP_DIGIT)
            begin
                if (opnd_depth >= STACK_DEPTH_DEF)
                    latched_err = ST_OVERFLOW;
                else
                begin
                    opnd[opnd_depth] = DATA_W'(c - CHAR_ZERO);
                    opnd_depth++;
                end
            end
            else if (op == OP_BAD)
                latched_err = ST_BADCHAR;
            else if (opnd_depth < 2)
                latched_err = ST_UNDERFLOW;
            else
            begin
                rhs = opnd[opnd_depth - 1];
                lhs = opnd[opnd_depth - 2];
                res = '0;
                case (op)
                    OP_ADD:  res = lhs + rhs;
                    OP_SUB:  res = lhs - rhs;
                    OP_MUL:  res = lhs * rhs;
                    default: if (rhs != '0) res = quot_trunc(lhs, rhs);
                endcase
                if (op == OP_DIV && rhs == '0)
                    latched_err = ST_DIVZERO;
                else
                begin
                    opnd_depth--;
                    opnd[opnd_depth - 1] = res;
                end
            end
        end
        if (fin)
        begin
            st  = latched_err;
            top = VAL_ERROR;
            if (st == ST_OK)
            begin
                if (opnd_depth == 0)
                    st = ST_EMPTY;
                else
                    top = opnd[opnd_depth - 1];
            end
            pending_values.push_back(top);
            pending_status.push_back(st);
            opnd_depth  = 0;
            latched_err = ST_OK;
        end
    endtask

    task automatic check_result();
        logic [DATA_W-1:0] want_v;
        status_t           want_s;
        if (pending_status.size() == 0)
        begin
            report_mismatch($sformatf("result with none pending: value %0d status %0d",
                                      value, status));
            return;
        end
        want_v = pending_values.pop_front();
        want_s = pending_status.pop_front();
        results_checked++;
        if (want_s != ST_OK)
            error_results++;
        if (value !== want_v)
            report_mismatch($sformatf("value: got %0d, expected %0d (status %s)",
                                      value, $signed(want_v), want_s.name()));
        if (status !== want_s)
            report_mismatch($sformatf("status: got %0d, expected %s", status,
                                      want_s.name()));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opnd_depth  = 0;
            latched_err = ST_OK;
            pending     <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                eval_char(ch, last);
            if (out_valid && !out_stall)
                check_result();
            pending <= pending_status.size();
        end
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Top of the postfix expression evaluator bench: clock, reset, character requests
// and result back-pressure; the verdict comes from pfe_result_checker. Depends on it, pfe_pkg and the evaluator.
module testbench;
    import pfe_pkg::*;

    localparam int HALF_PERIOD     = 5;
    localparam int ITEM_TARGET     = 1550;
    localparam int HOLD_OFF_CYCLES = 2000;

    // Kinds of expression the random phase builds.
    typedef enum int {
        SHAPE_WELL,
        SHAPE_WRAP,
        SHAPE_DEEP,
        SHAPE_MINDIV,
        SHAPE_BROKEN,
        SHAPE_NOISE,
        SHAPE_COUNT
    } shape_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [7:0]               ch;
    logic                     last;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [DATA_W-1:0] value;
    logic [2:0]               status;

    int fail_count;
    int pending;
    int results_checked;
    int error_results;

    logic [7:0] expr_q [$];   // characters of the expression being built
    int         chars_sent;
    int         exprs_sent;
    bit         quiet_send;   // send the current expression back to back
    bit         random_phase; // arms the long receiver hold-off

    always #HALF_PERIOD clk = ~clk;

    postfix_expression_evaluator #(
        .STACK_DEPTH (STACK_DEPTH_DEF)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .ch        (ch),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .status    (status)
    );

    pfe_result_checker result_chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .ch              (ch),
        .last            (last),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .value           (value),
        .status          (status),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .error_results   (error_results)
    );

    // Idle length for either side: mostly none, often short, rarely long.
    function automatic int idle_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    function automatic logic [7:0] rand_digit(int lo = 0);
        return CHAR_ZERO + 8'($urandom_range(lo, 9));
    endfunction

    function automatic logic [7:0] rand_op();
        case ($urandom_range(0, 3))
            0:       return CHAR_ADD;
            1:       return CHAR_SUB;
            2:       return CHAR_MUL;
            default: return CHAR_DIV;
        endcase
    endfunction

    function automatic shape_t pick_shape();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return SHAPE_WELL;
        if (roll < 67) return SHAPE_WRAP;
        if (roll < 70) return SHAPE_DEEP;
        if (roll < 74) return SHAPE_MINDIV;
        if (roll < 88) return SHAPE_BROKEN;
        return SHAPE_NOISE;
    endfunction

    // Offer one character request and hold it until the block takes it,
    // then drop valid for a random gap unless the next request follows at once.
    task automatic send_char(logic [7:0] c, logic fin);
        int gap;
        in_valid <= 1'b1;
        ch       <= c;
        last     <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        chars_sent++;
        gap = quiet_send ? 0 : idle_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Send the built expression, flagging its final character, and clear it.
    task automatic send_expr();
        for (int i = 0; i < expr_q.size(); i++)
            send_char(expr_q[i], i == expr_q.size() - 1);
        expr_q.delete();
        exprs_sent++;
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            expr_q.push_back(s[i]);
    endtask

    task automatic run_text(string s);
        push_text(s);
        send_expr();
    endtask

    // Well-formed postfix: push while the stack is shallow, otherwise mostly reduce;
    // usually fold down to a single operand at the end, sometimes leave extras.
    task automatic build_well(int len);
        int depth;
        depth = 0;
        for (int i = 0; i < len; i++)
        begin
            if (depth < 2 || ($urandom_range(0, 2) == 0 && depth < 40))
            begin
                expr_q.push_back(rand_digit());
                depth++;
            end
            else
            begin
                expr_q.push_back(rand_op());
                depth--;
            end
        end
        if ($urandom_range(0, 4) != 0)
            while (depth > 1)
            begin
                expr_q.push_back(rand_op());
                depth--;
            end
    endtask

    // Chain of mostly multiplies on nonzero digits so the running value can wrap past 32 bits.
    task automatic build_wrap();
        expr_q.push_back(rand_digit(2));
        repeat ($urandom_range(6, 16))
        begin
            expr_q.push_back(rand_digit(2));
            expr_q.push_back(($urandom_range(0, 3) == 0) ? rand_op() : CHAR_MUL);
        end
        if ($urandom_range(0, 1) == 1)
            push_text("01-*");
        if ($urandom_range(0, 2) == 0)
        begin
            expr_q.push_back(rand_digit());
            expr_q.push_back(CHAR_DIV);
        end
    endtask

    // Fill the operand stack to around its depth; past it the push overflows.
    task automatic build_deep(int n);
        repeat (n) expr_q.push_back(rand_digit());
        repeat ($urandom_range(0, 6)) expr_q.push_back(rand_op());
    endtask

    // Build the most negative value as 2 to the 31st, then combine it with a small operand.
    task automatic build_mindiv(bit forced);
        push_text("2");
        repeat (30) push_text("2*");
        if (forced)
            push_text("01-/");
        else
            case ($urandom_range(0, 4))
                0:       push_text("01-/");
                1:       push_text("01-*");
                2:       push_text("1-");
                3:       push_text("3/");
                default: push_text("0/");
            endcase
    endtask

    // Well-formed expression with one character swapped for a random byte or operator.
    task automatic build_broken();
        int idx;
        build_well($urandom_range(2, 12));
        idx = $urandom_range(0, expr_q.size() - 1);
        expr_q[idx] = ($urandom_range(0, 1) == 1) ? rand_op() : 8'($urandom_range(0, 255));
    endtask

    // Receiver: random stall pattern with quiet stretches, plus one long hold-off
    // at the start of the random phase so the command queue fills and the block
    // stalls its input while the sender keeps offering requests.
    initial
    begin
        int n;
        bit hold_done;
        out_stall = 1'b0;
        hold_done = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (random_phase && !hold_done)
            begin
                n         = HOLD_OFF_CYCLES;
                hold_done = 1'b1;
            end
            else
                n = idle_cycles();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(30, 100)
                                                : $urandom_range(1, 6)) @(posedge clk);
        end
    end

    // Watchdog: end the run if the block hangs or drops results.
    initial
    begin
        #10ms;
        $display("timeout with %0d results still pending", pending);
        $display("[postfix_expression_evaluator] ERROR");
        $finish;
    end

    initial
    begin
        shape_t shape;
        int     exprs_random;
        in_valid     = 1'b0;
        ch           = '0;
        last         = 1'b0;
        rst_n        = 1'b0;
        chars_sent   = 0;
        exprs_sent   = 0;
        exprs_random = 0;
        quiet_send   = 1'b0;
        random_phase = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: digit extremes and every operator, including a negative quotient.
        run_text("9");
        run_text("78*");
        run_text("34+");
        run_text("09-4/");
        // Operator short of operands, zero divisor on the final character.
        run_text("5+");
        run_text("50/");
        // Latched error: characters after the first error are ignored.
        run_text("5+3");
        // Bad characters at both ends of the byte range, each on the final character.
        expr_q.push_back(8'h00);
        send_expr();
        push_text("1");
        expr_q.push_back(8'hFF);
        send_expr();
        // Leftover operands: top of stack is reported.
        run_text("123");

        // Random phase: take every shape once, then draw them by weight.
        random_phase <= 1'b1;
        while (chars_sent < ITEM_TARGET)
        begin
            shape      = (exprs_random < SHAPE_COUNT) ? shape_t'(exprs_random) : pick_shape();
            quiet_send = ($urandom_range(0, 9) == 0);
            case (shape)
                SHAPE_WELL:   build_well(($urandom_range(0, 7) == 0) ? $urandom_range(16, 40)
                                                                     : $urandom_range(1, 15));
                SHAPE_WRAP:   build_wrap();
                SHAPE_DEEP:   build_deep((exprs_random < SHAPE_COUNT) ? STACK_DEPTH_DEF + 1
                                                                      : $urandom_range(60, 66));
                SHAPE_MINDIV: build_mindiv(exprs_random < SHAPE_COUNT);
                SHAPE_BROKEN: build_broken();
                default:      repeat ($urandom_range(1, 6))
                                  expr_q.push_back(8'($urandom_range(0, 255)));
            endcase
            send_expr();
            exprs_random++;
        end
        quiet_send = 1'b0;
        in_valid <= 1'b0;

        // Drain: wait for every predicted result, then long enough for a divide
        // plus a receiver stall so that any stray result still shows up.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        $display("Run covered %0d characters in %0d expressions; %0d results checked, %0d %s",
                 chars_sent, exprs_sent, results_checked, error_results,
                 "of them with an error status.");
        $display("The receiver held off once for %0d cycles to back the block up to its input.",
                 HOLD_OFF_CYCLES);
        if (fail_count == 0)
            $display("[postfix_expression_evaluator] OK");
        else
            $display("[postfix_expression_evaluator] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
design/pfe_pkg.sv
design/pfe_front.sv
design/pfe_queue.sv
design/pfe_div.sv
design/pfe_back.sv
design/postfix_expression_evaluator.sv
bench/pfe_result_checker.sv
bench/testbench.sv
